@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for the concurrent checks of the quaternion ALU.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define QALU_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("quaternion ALU check failed");

// The antecedent implies the consequent in the following cycle.
`define QALU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("quaternion ALU check failed");

`endif

@@ hw/rtl/qalu_pkg.sv @@
// ----------------------------------------------------------------------------
// qalu_pkg
// Constants, types and step functions shared by the quaternion ALU modules.
// ----------------------------------------------------------------------------
package qalu_pkg;

    localparam int FIELD_W     = 32;
    localparam int FRAC_BITS   = 16;
    localparam int OPW         = 32;
    localparam int PROD_W      = 2 * OPW;
    localparam int SQ_W        = PROD_W + 1;
    localparam int HS_W        = PROD_W + 2;
    localparam int ROOT_W      = OPW + 1;
    localparam int RAD_W       = 2 * ROOT_W;
    localparam int DEN_W       = SQ_W - FRAC_BITS;
    localparam int NUM_W       = DEN_W + 1;
    localparam int TOL_W       = 16;
    localparam int CFG_AW      = 3;
    localparam int CFG_DW      = 32;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [0:0]       IDX_TOL   = 1'b0;
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(66);

    localparam logic [2:0] OP_MUL  = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_CONJ = 3'd3;
    localparam logic [2:0] OP_INV  = 3'd4;
    localparam logic [2:0] OP_NORM = 3'd5;
    localparam logic [2:0] OP_LEN  = 3'd6;
    localparam logic [2:0] OP_UNIT = 3'd7;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

    localparam logic [OPW-1:0] WORD_MAX = {1'b0, {(OPW-1){1'b1}}};
    localparam logic [OPW-1:0] WORD_MIN = {1'b1, {(OPW-1){1'b0}}};
    localparam logic signed [HS_W-1:0] MUL_HALF = HS_W'(1) <<< (FRAC_BITS - 1);
    localparam logic [SQ_W-1:0] SQ_ONE = SQ_W'(1) << (2 * FRAC_BITS);

    // Hamilton product: which b component pairs with a[t] for result c,
    // and which of the four terms is subtracted.
    localparam int unsigned HAM_IDX [4][4] = '{'{0, 1, 2, 3}, '{1, 0, 3, 2},
                                             '{2, 3, 0, 1}, '{3, 2, 1, 0}};
    localparam logic [3:0] HAM_NEG [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

    typedef logic [3:0][OPW-1:0] t_quat;

    typedef struct packed {
        logic [2:0] op;
        t_quat      a;
        t_quat      b;
        t_quat      res;
        logic       sat;
    } t_item;

    typedef struct packed {
        logic [2:0]       op;
        t_quat            a;
        t_quat            res;
        logic             sat;
        logic             dz;
        logic             zq;
        logic             is_unit;
        logic [OPW-1:0]   norm;
        logic [DEN_W-1:0] den;
        logic [3:0]       neg;
    } t_side;

    typedef struct packed {
        logic [OPW-1:0] val;
        logic           sat;
    } t_satw;

    typedef struct packed {
        logic [ROOT_W:0]   rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
    } t_sq_st;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] work;
        logic [DEN_W-1:0] den;
    } t_dv_st;

    function automatic t_satw sat_s(input logic signed [HS_W-1:0] v);
        logic signed [HS_W-1:0] hi;
        logic signed [HS_W-1:0] lo;
        t_satw r;
        hi = {{(HS_W-OPW+1){1'b0}}, {(OPW-1){1'b1}}};
        lo = ~hi;
        if (v > hi) begin
            r.val = WORD_MAX;
            r.sat = 1'b1;
        end else if (v < lo) begin
            r.val = WORD_MIN;
            r.sat = 1'b1;
        end else begin
            r.val = v[OPW-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    // One digit of the restoring square root: two radicand bits in, one root bit out.
    function automatic t_sq_st sqrt_step(input t_sq_st s);
        logic [ROOT_W+2:0] rem2;
        logic [ROOT_W+2:0] trial;
        logic [ROOT_W+2:0] diff;
        t_sq_st r;
        rem2  = {s.rem, s.rad[RAD_W-1 -: 2]};
        trial = {1'b0, s.root, 2'b01};
        diff  = rem2 - trial;
        r.rad = {s.rad[RAD_W-3:0], 2'b00};
        if (rem2 >= trial) begin
            r.rem  = diff[ROOT_W:0];
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            r.rem  = rem2[ROOT_W:0];
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // One bit of restoring division; quotient bits shift in behind the numerator.
    function automatic t_dv_st div_step(input t_dv_st s);
        logic [DEN_W:0] rem2;
        logic [DEN_W:0] diff;
        t_dv_st r;
        rem2  = {s.rem, s.work[NUM_W-1]};
        diff  = rem2 - {1'b0, s.den};
        r.den = s.den;
        if (rem2 >= {1'b0, s.den}) begin
            r.rem  = diff[DEN_W-1:0];
            r.work = {s.work[NUM_W-2:0], 1'b1};
        end else begin
            r.rem  = rem2[DEN_W-1:0];
            r.work = {s.work[NUM_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/qalu_front.sv @@
// ----------------------------------------------------------------------------
// qalu_front
// Request intake: takes a beat, works out the add, subtract and conjugate
// results and passes the classified request to the queue.
// ----------------------------------------------------------------------------
module qalu_front (
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_req_type,
    input  qalu_pkg::t_quat    i_a,
    input  qalu_pkg::t_quat    i_b,
    input  logic               i_full,
    output logic               o_push,
    output qalu_pkg::t_item    o_item
);
    import qalu_pkg::*;

    logic signed [HS_W-1:0] w_sa [4];
    logic signed [HS_W-1:0] w_sb [4];
    logic signed [HS_W-1:0] w_v  [4];
    t_satw                  w_s  [4];

    always_comb begin
        o_item.op  = i_req_type;
        o_item.a   = i_a;
        o_item.b   = i_b;
        o_item.sat = 1'b0;
        for (int c = 0; c < 4; c++) begin
            w_sa[c] = HS_W'($signed(i_a[c]));
            w_sb[c] = HS_W'($signed(i_b[c]));
            case (i_req_type)
                OP_ADD:  w_v[c] = w_sa[c] + w_sb[c];
                OP_SUB:  w_v[c] = w_sa[c] - w_sb[c];
                OP_CONJ: w_v[c] = (c == 0) ? w_sa[c] : -w_sa[c];
                default: w_v[c] = '0;
            endcase
            w_s[c]        = sat_s(w_v[c]);
            o_item.res[c] = w_s[c].val;
            o_item.sat    = o_item.sat | w_s[c].sat;
        end
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

endmodule

@@ hw/rtl/qalu_fifo.sv @@
// ----------------------------------------------------------------------------
// qalu_fifo
// Short request queue between the intake and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module qalu_fifo #(
    parameter int DEPTH = qalu_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  qalu_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output qalu_pkg::t_item o_item
);
    import qalu_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item         r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          w_wr;
    logic          w_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

@@ hw/rtl/qalu_sqrt.sv @@
// ----------------------------------------------------------------------------
// qalu_sqrt
// Pipelined restoring square root, one root bit per stage, rounded to
// nearest at the end. Carries the request's side data alongside.
// ----------------------------------------------------------------------------
module qalu_sqrt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [qalu_pkg::RAD_W-1:0]     i_rad,
    input  qalu_pkg::t_side                i_side,
    output logic                           o_valid,
    output logic [qalu_pkg::ROOT_W-1:0]    o_root,
    output qalu_pkg::t_side                o_side
);
    import qalu_pkg::*;

    t_sq_st            r_st [ROOT_W];
    t_side             r_sd [ROOT_W];
    logic [ROOT_W-1:0] r_v;
    t_sq_st            w_init;
    t_sq_st            w_last;
    logic [ROOT_W-1:0] r_root;
    t_side             r_side;
    logic              r_ov;

    always_comb begin
        w_init.rem  = '0;
        w_init.root = '0;
        w_init.rad  = i_rad;
        w_last      = r_st[ROOT_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_v  <= {r_v[ROOT_W-2:0], i_valid};
            r_ov <= r_v[ROOT_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= sqrt_step(w_init);
            r_sd[0] <= i_side;
            for (int s = 1; s < ROOT_W; s++) begin
                r_st[s] <= sqrt_step(r_st[s-1]);
                r_sd[s] <= r_sd[s-1];
            end
            // The remainder exceeds the floor root exactly when the true root
            // lies at or above the half-way point.
            r_root <= w_last.root
                      + ROOT_W'(w_last.rem > {1'b0, w_last.root});
            r_side <= r_sd[ROOT_W-1];
        end
    end

    assign o_valid = r_ov;
    assign o_root  = r_root;
    assign o_side  = r_side;

endmodule

@@ hw/rtl/qalu_div.sv @@
// ----------------------------------------------------------------------------
// qalu_div
// One lane of pipelined unsigned restoring division, one quotient bit per
// stage.
// ----------------------------------------------------------------------------
module qalu_div (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [qalu_pkg::NUM_W-1:0] i_num,
    input  logic [qalu_pkg::DEN_W-1:0] i_den,
    output logic [qalu_pkg::NUM_W-1:0] o_quo
);
    import qalu_pkg::*;

    t_dv_st r_st [NUM_W];
    t_dv_st w_init;

    always_comb begin
        w_init.rem  = '0;
        w_init.work = i_num;
        w_init.den  = i_den;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= div_step(w_init);
            for (int s = 1; s < NUM_W; s++) begin
                r_st[s] <= div_step(r_st[s-1]);
            end
        end
    end

    assign o_quo = r_st[NUM_W-1].work;

endmodule

@@ hw/rtl/qalu_back.sv @@
// ----------------------------------------------------------------------------
// qalu_back
// Arithmetic pipeline: products and squares, sums, rounding, square root,
// four division lanes and the result register.
// ----------------------------------------------------------------------------
module qalu_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [qalu_pkg::TOL_W-1:0] i_tol,
    input  logic                       i_empty,
    input  qalu_pkg::t_item            i_item,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output qalu_pkg::t_quat            o_res,
    output logic [qalu_pkg::OPW-1:0]   o_norm,
    output logic                       o_is_unit,
    output logic [1:0]                 o_status
);
    import qalu_pkg::*;

    logic                     w_adv;

    // Products and squares.
    logic                     r_b1_v;
    t_side                    r_b1_side;
    t_side                    w_b1_side;
    logic signed [PROD_W-1:0] r_p  [4][4];
    logic signed [PROD_W-1:0] r_sq [4];

    // Sums.
    logic                     r_b2_v;
    t_side                    r_b2_side;
    logic signed [HS_W-1:0]   r_hs [4];
    logic [SQ_W-1:0]          r_n2;
    logic signed [HS_W-1:0]   w_hs [4];
    logic [SQ_W-1:0]          w_n2;

    // Rounding, inverse divisor and unit test.
    logic                     r_b3_v;
    t_side                    r_b3_side;
    logic [RAD_W-1:0]         r_b3_rad;
    t_side                    w_b3_side;
    logic signed [HS_W-1:0]   w_rnd [4];
    t_satw                    w_ms  [4];
    logic [DEN_W-1:0]         w_q;
    logic [SQ_W-1:0]          w_e;

    // Square root.
    logic                     w_sq_v;
    logic [ROOT_W-1:0]        w_root;
    t_side                    w_sq_side;

    // Division set-up.
    logic                     r_b4_v;
    t_side                    r_b4_side;
    logic [NUM_W-1:0]         r_b4_num [4];
    logic [DEN_W-1:0]         r_b4_den;
    t_side                    w_b4_side;
    logic signed [OPW:0]      w_x   [4];
    logic signed [OPW:0]      w_mag [4];
    logic [NUM_W-1:0]         w_num [4];

    // Division and result.
    logic [NUM_W-1:0]         r_dv_v;
    t_side                    r_dside [NUM_W];
    logic [NUM_W-1:0]         w_quo [4];
    t_side                    w_fs;
    logic signed [HS_W-1:0]   w_qv [4];
    t_satw                    w_qs [4];
    t_quat                    w_res;
    logic                     w_sat;
    logic                     r_out_valid;
    t_quat                    r_res;
    logic [OPW-1:0]           r_norm;
    logic                     r_unit;
    logic [1:0]               r_status;

    assign w_adv = !r_out_valid || i_ready;
    assign o_pop = w_adv && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v      <= 1'b0;
            r_b2_v      <= 1'b0;
            r_b3_v      <= 1'b0;
            r_b4_v      <= 1'b0;
            r_dv_v      <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_b1_v      <= !i_empty;
            r_b2_v      <= r_b1_v;
            r_b3_v      <= r_b2_v;
            r_b4_v      <= w_sq_v;
            r_dv_v      <= {r_dv_v[NUM_W-2:0], r_b4_v};
            r_out_valid <= r_dv_v[NUM_W-1];
        end
    end

    always_comb begin
        w_b1_side     = '0;
        w_b1_side.op  = i_item.op;
        w_b1_side.a   = i_item.a;
        w_b1_side.res = i_item.res;
        w_b1_side.sat = i_item.sat;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b1_side <= w_b1_side;
            for (int c = 0; c < 4; c++) begin
                for (int t = 0; t < 4; t++) begin
                    r_p[c][t] <= $signed(i_item.a[t]) * $signed(i_item.b[HAM_IDX[c][t]]);
                end
                r_sq[c] <= $signed(i_item.a[c]) * $signed(i_item.a[c]);
            end
        end
    end

    always_comb begin
        w_n2 = '0;
        for (int c = 0; c < 4; c++) begin
            w_hs[c] = '0;
            for (int t = 0; t < 4; t++) begin
                if (HAM_NEG[c][t]) begin
                    w_hs[c] = w_hs[c] - HS_W'(r_p[c][t]);
                end else begin
                    w_hs[c] = w_hs[c] + HS_W'(r_p[c][t]);
                end
            end
            w_n2 = w_n2 + {1'b0, r_sq[c]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b2_side <= r_b1_side;
            r_hs      <= w_hs;
            r_n2      <= w_n2;
        end
    end

    always_comb begin
        w_b3_side = r_b2_side;
        w_q = DEN_W'(r_n2 >> FRAC_BITS) + DEN_W'(r_n2[FRAC_BITS-1]);
        w_e = SQ_W'(i_tol) << FRAC_BITS;
        for (int c = 0; c < 4; c++) begin
            w_rnd[c] = (r_hs[c] + MUL_HALF) >>> FRAC_BITS;
            w_ms[c]  = sat_s(w_rnd[c]);
        end
        case (r_b2_side.op)
            OP_MUL: begin
                for (int c = 0; c < 4; c++) begin
                    w_b3_side.res[c] = w_ms[c].val;
                end
                w_b3_side.sat = w_ms[0].sat | w_ms[1].sat | w_ms[2].sat | w_ms[3].sat;
            end
            OP_INV: begin
                w_b3_side.den = w_q;
                w_b3_side.dz  = (r_n2 == '0);
                // A tiny nonzero norm that rounds to zero saturates instead.
                w_b3_side.zq  = (w_q == '0) && (r_n2 != '0);
            end
            OP_UNIT: begin
                w_b3_side.is_unit = (r_n2 >= SQ_ONE - w_e) && (r_n2 <= SQ_ONE + w_e);
            end
            default: begin
                w_b3_side = r_b2_side;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b3_side <= w_b3_side;
            r_b3_rad  <= RAD_W'(r_n2);
        end
    end

    qalu_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_b3_v),
        .i_rad   (r_b3_rad),
        .i_side  (r_b3_side),
        .o_valid (w_sq_v),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    always_comb begin
        w_b4_side = w_sq_side;
        case (w_sq_side.op)
            OP_NORM: begin
                w_b4_side.den = DEN_W'(w_root);
                w_b4_side.dz  = (w_root == '0);
            end
            OP_LEN: begin
                if (w_root > {1'b0, {OPW{1'b1}}}) begin
                    w_b4_side.norm = '1;
                    w_b4_side.sat  = 1'b1;
                end else begin
                    w_b4_side.norm = w_root[OPW-1:0];
                end
            end
            default: begin
                w_b4_side = w_sq_side;
            end
        endcase
        for (int c = 0; c < 4; c++) begin
            w_x[c] = (OPW+1)'($signed(w_sq_side.a[c]));
            if (w_sq_side.op == OP_INV && c != 0) begin
                w_x[c] = -w_x[c];
            end
            w_b4_side.neg[c] = w_x[c] < 0;
            w_mag[c] = w_b4_side.neg[c] ? -w_x[c] : w_x[c];
            // Half the divisor is added first so that the quotient rounds to
            // nearest with ties away from zero.
            w_num[c] = (NUM_W'(w_mag[c][OPW-1:0]) << FRAC_BITS)
                       + NUM_W'(w_b4_side.den >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b4_side <= w_b4_side;
            r_b4_num  <= w_num;
            r_b4_den  <= w_b4_side.den;
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        qalu_div u_div (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_num (r_b4_num[g]),
            .i_den (r_b4_den),
            .o_quo (w_quo[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dside[0] <= r_b4_side;
            for (int s = 1; s < NUM_W; s++) begin
                r_dside[s] <= r_dside[s-1];
            end
        end
    end

    always_comb begin
        w_fs  = r_dside[NUM_W-1];
        w_res = w_fs.res;
        w_sat = w_fs.sat;
        for (int c = 0; c < 4; c++) begin
            w_qv[c] = HS_W'($signed({1'b0, w_quo[c]}));
            if (w_fs.neg[c]) begin
                w_qv[c] = -w_qv[c];
            end
            w_qs[c] = sat_s(w_qv[c]);
        end
        if (w_fs.op == OP_INV || w_fs.op == OP_NORM) begin
            for (int c = 0; c < 4; c++) begin
                if (w_fs.dz) begin
                    w_res[c] = '0;
                end else if (w_fs.zq) begin
                    if (w_fs.a[c] == '0) begin
                        w_res[c] = '0;
                    end else begin
                        w_res[c] = w_fs.neg[c] ? WORD_MIN : WORD_MAX;
                        w_sat    = 1'b1;
                    end
                end else begin
                    w_res[c] = w_qs[c].val;
                    w_sat    = w_sat | w_qs[c].sat;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res  <= w_res;
            r_norm <= w_fs.norm;
            r_unit <= w_fs.is_unit;
            if (w_fs.dz) begin
                r_status <= ST_DZ;
            end else if (w_sat) begin
                r_status <= ST_SAT;
            end else begin
                r_status <= ST_OK;
            end
        end
    end

    assign o_valid   = r_out_valid;
    assign o_res     = r_res;
    assign o_norm    = r_norm;
    assign o_is_unit = r_unit;
    assign o_status  = r_status;

endmodule

@@ hw/rtl/quaternion_alu_core.sv @@
// ----------------------------------------------------------------------------
// quaternion_alu_core
// Quaternion arithmetic unit in signed Q16.16 with a request queue.
// ----------------------------------------------------------------------------
// Each request beat carries an operation code and one or two quaternions and
// yields exactly one result beat, in order. The unit is fully pipelined and
// sustains one request per clock cycle while results are taken at the output;
// every request passes through the 33-stage square root and the 50-stage
// division lanes. Products and squares take one stage of 32 by 32 bit
// multipliers. The tolerance register at byte address 0 resets to 66 and
// should be written only while the unit is empty.
`include "assert_macros.svh"

module quaternion_alu_core #(
    parameter int QDEPTH = qalu_pkg::QUEUE_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [2:0]                         i_req_type,
    input  logic signed [qalu_pkg::FIELD_W-1:0] i_a_scalar,
    input  logic signed [qalu_pkg::FIELD_W-1:0] i_a_i,
    input  logic signed [qalu_pkg::FIELD_W-1:0] i_a_j,
    input  logic signed [qalu_pkg::FIELD_W-1:0] i_a_k,
    input  logic signed [qalu_pkg::FIELD_W-1:0] i_b_scalar,
    input  logic signed [qalu_pkg::FIELD_W-1:0] i_b_i,
    input  logic signed [qalu_pkg::FIELD_W-1:0] i_b_j,
    input  logic signed [qalu_pkg::FIELD_W-1:0] i_b_k,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [qalu_pkg::FIELD_W-1:0] o_r_scalar,
    output logic signed [qalu_pkg::FIELD_W-1:0] o_r_i,
    output logic signed [qalu_pkg::FIELD_W-1:0] o_r_j,
    output logic signed [qalu_pkg::FIELD_W-1:0] o_r_k,
    output logic [qalu_pkg::FIELD_W-1:0]        o_norm_value,
    output logic                               o_is_unit,
    output logic [1:0]                         o_status,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [qalu_pkg::CFG_AW-1:0]         paddr,
    input  logic [qalu_pkg::CFG_DW-1:0]         pwdata,
    output logic [qalu_pkg::CFG_DW-1:0]         prdata,
    output logic                               pready
);
    import qalu_pkg::*;

    logic [TOL_W-1:0] r_tol;
    t_quat            w_a;
    t_quat            w_b;
    logic             w_push;
    logic             w_full;
    logic             w_pop;
    logic             w_empty;
    t_item            w_item;
    t_item            w_qitem;
    t_quat            w_res;
    logic [OPW-1:0]   w_norm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (psel && penable && pwrite && paddr[CFG_AW-1] == IDX_TOL) begin
            r_tol <= pwdata[TOL_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[CFG_AW-1] == IDX_TOL) ? CFG_DW'(r_tol) : '0;

    assign w_a[0] = i_a_scalar[OPW-1:0];
    assign w_a[1] = i_a_i[OPW-1:0];
    assign w_a[2] = i_a_j[OPW-1:0];
    assign w_a[3] = i_a_k[OPW-1:0];
    assign w_b[0] = i_b_scalar[OPW-1:0];
    assign w_b[1] = i_b_i[OPW-1:0];
    assign w_b[2] = i_b_j[OPW-1:0];
    assign w_b[3] = i_b_k[OPW-1:0];

    qalu_front u_front (
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .i_a        (w_a),
        .i_b        (w_b),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_item     (w_item)
    );

    qalu_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_item  (w_qitem)
    );

    qalu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tol     (r_tol),
        .i_empty   (w_empty),
        .i_item    (w_qitem),
        .o_pop     (w_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_res     (w_res),
        .o_norm    (w_norm),
        .o_is_unit (o_is_unit),
        .o_status  (o_status)
    );

    assign o_r_scalar   = FIELD_W'($signed(w_res[0]));
    assign o_r_i        = FIELD_W'($signed(w_res[1]));
    assign o_r_j        = FIELD_W'($signed(w_res[2]));
    assign o_r_k        = FIELD_W'($signed(w_res[3]));
    assign o_norm_value = FIELD_W'(w_norm);

    // A zero norm clears every result field.
    `QALU_ASSERT_SAME(a_dz_zero, o_valid && o_status == ST_DZ, o_r_scalar == '0 && o_r_i == '0 && o_r_j == '0 && o_r_k == '0 && o_norm_value == '0)
    // A passing unit test carries no quaternion and a clean status.
    `QALU_ASSERT_SAME(a_unit_clean, o_valid && o_is_unit, o_status == ST_OK && o_r_scalar == '0 && o_norm_value == '0)
    // A queue that reports full has taken a beat and is not empty next cycle unless it was popped.
    `QALU_ASSERT_NEXT(a_full_not_empty, w_full, !w_empty || $past(w_pop))

endmodule
